// File: hdl/bsvr_pkg.sv
`default_nettype none

package bsvr_pkg;

    localparam int KEY_W   = 23;
    localparam int DEPTH_W = 7;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [KEY_W-1:0]   date_key;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   top_date;
        logic [DEPTH_W-1:0] depth;
        logic               is_empty;
    } rsp_t;

endpackage

`default_nettype wire

// File: hdl/bsvr_ram.sv
`default_nettype none

module bsvr_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/bounded_stack_with_value_removal.sv
`default_nettype none

// Bounded stack of 23-bit packed date keys held in one single-port-write,
// single-port-read RAM of CAPACITY entries. Each command transaction yields
// exactly one response transaction describing the stack after the command.
// Push, pop and peek first update the RAM and count, then read the new top
// from the RAM, then load the response register. Remove scans from the bottom
// one RAM read per cycle and then shifts the higher entries down one RAM read
// and write per cycle. The command channel stalls for the whole command; a
// finished response may wait in its register while the next command is
// accepted. No clearing pass is needed after reset.
module bounded_stack_with_value_removal #(
    parameter int CAPACITY = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire bsvr_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bsvr_pkg::rsp_t     rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_READ_TOP,
        S_LOAD
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [bsvr_pkg::KEY_W-1:0]     key_reg, key_next;
    bsvr_pkg::status_t              status_reg, status_next;
    bsvr_pkg::rsp_t                 rsp_reg, rsp_next;
    logic                           rsp_valid_reg, rsp_valid_next;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [bsvr_pkg::KEY_W-1:0]     ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [bsvr_pkg::KEY_W-1:0]     ram_rdata;

    logic [CW-1:0]                  idx_inc;
    logic [AW-1:0]                  top_addr;

    assign idx_inc  = CW'(idx_reg) + CW'(1);
    assign top_addr = AW'(count_reg - CW'(1));

    bsvr_ram #(
        .WIDTH (bsvr_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = top_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next    = cmd.date_key;
                    status_next = bsvr_pkg::STATUS_OK;
                    state_next  = S_READ_TOP;
                    unique case (cmd.mode)
                        bsvr_pkg::MODE_PUSH:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = bsvr_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = cmd.date_key;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bsvr_pkg::MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bsvr_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        bsvr_pkg::MODE_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bsvr_pkg::STATUS_EMPTY;
                            end
                        end
                        bsvr_pkg::MODE_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bsvr_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next   = '0;
                                ram_raddr  = '0;
                                state_next = S_SEARCH;
                            end
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                ram_raddr = AW'(idx_inc);
                if (ram_rdata == key_reg)
                begin
                    if (idx_inc >= count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_READ_TOP;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_inc >= count_reg)
                begin
                    status_next = bsvr_pkg::STATUS_NOT_FOUND;
                    state_next  = S_READ_TOP;
                end
                else
                begin
                    idx_next = AW'(idx_inc);
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                ram_raddr = AW'(idx_inc + CW'(1));
                idx_next  = AW'(idx_inc);
                if ((idx_inc + CW'(1)) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_READ_TOP;
                end
            end
            S_READ_TOP:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status   = status_reg;
                    rsp_next.top_date = (count_reg == '0) ? '0 : ram_rdata;
                    rsp_next.depth    = bsvr_pkg::DEPTH_W'(count_reg);
                    rsp_next.is_empty = (count_reg == '0);
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            key_reg       <= '0;
            status_reg    <= bsvr_pkg::STATUS_OK;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            key_reg       <= key_next;
            status_reg    <= status_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != S_IDLE))
        else $error("command transaction accepted without starting work");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_inc < count_reg))
        else $error("shift source beyond stored entries");

endmodule

`default_nettype wire

// File: dv/bounded_stack_with_value_removal_tb.sv
`timescale 1ns / 100ps

module bounded_stack_with_value_removal_tb;

    localparam int CAP            = 64;
    localparam int RAND_PER_PHASE = 470;
    localparam int REGIME_LEN     = 40;
    localparam int QUIET_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 150;
    localparam int SND_IDLE[3]    = '{20, 71, 0};
    localparam int RCV_STALL[3]   = '{71, 20, 0};

    typedef struct packed {
        logic           typed;
        bsvr_pkg::cmd_t c;
        bsvr_pkg::rsp_t r;
    } dir_row_t;

    localparam int DIR_N = 20;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    bsvr_pkg::cmd_t cmd       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    bsvr_pkg::rsp_t rsp;

    logic [bsvr_pkg::KEY_W-1:0] stack_keys [CAP];
    int                         stack_depth   = 0;
    bsvr_pkg::rsp_t             rsp_expected [$];
    int                         errors        = 0;
    int                         quiet_cycles  = 0;
    int                         snd_idle_pct  = 0;
    int                         rcv_stall_pct = 0;

    dir_row_t dir_rows [DIR_N] = '{
        '{1'b1, '{bsvr_pkg::MODE_POP,    23'h000000},
          '{bsvr_pkg::STATUS_EMPTY,     23'h000000, 7'd0, 1'b1}},
        '{1'b1, '{bsvr_pkg::MODE_PEEK,   23'h000000},
          '{bsvr_pkg::STATUS_EMPTY,     23'h000000, 7'd0, 1'b1}},
        '{1'b1, '{bsvr_pkg::MODE_REMOVE, 23'h7FFFFF},
          '{bsvr_pkg::STATUS_NOT_FOUND, 23'h000000, 7'd0, 1'b1}},
        '{1'b1, '{bsvr_pkg::MODE_PUSH,   23'h000000},
          '{bsvr_pkg::STATUS_OK,        23'h000000, 7'd1, 1'b0}},
        '{1'b1, '{bsvr_pkg::MODE_PUSH,   23'h7FFFFF},
          '{bsvr_pkg::STATUS_OK,        23'h7FFFFF, 7'd2, 1'b0}},
        '{1'b1, '{bsvr_pkg::MODE_PEEK,   23'h000000},
          '{bsvr_pkg::STATUS_OK,        23'h7FFFFF, 7'd2, 1'b0}},
        '{1'b0, '{bsvr_pkg::MODE_PUSH,   23'h555555}, '0},
        '{1'b0, '{bsvr_pkg::MODE_PUSH,   23'h2AAAAA}, '0},
        '{1'b0, '{bsvr_pkg::MODE_PUSH,   23'h000000}, '0},
        '{1'b0, '{bsvr_pkg::MODE_PUSH,   23'h3F40CF}, '0},
        '{1'b0, '{bsvr_pkg::MODE_REMOVE, 23'h000000}, '0},
        '{1'b0, '{bsvr_pkg::MODE_REMOVE, 23'h123456}, '0},
        '{1'b0, '{bsvr_pkg::MODE_REMOVE, 23'h3F40CF}, '0},
        '{1'b0, '{bsvr_pkg::MODE_PEEK,   23'h555555}, '0},
        '{1'b0, '{bsvr_pkg::MODE_REMOVE, 23'h7FFFFF}, '0},
        '{1'b0, '{bsvr_pkg::MODE_POP,    23'h7FFFFF}, '0},
        '{1'b0, '{bsvr_pkg::MODE_POP,    23'h000000}, '0},
        '{1'b1, '{bsvr_pkg::MODE_POP,    23'h000000},
          '{bsvr_pkg::STATUS_OK,        23'h000000, 7'd0, 1'b1}},
        '{1'b1, '{bsvr_pkg::MODE_POP,    23'h2AAAAA},
          '{bsvr_pkg::STATUS_EMPTY,     23'h000000, 7'd0, 1'b1}},
        '{1'b1, '{bsvr_pkg::MODE_PEEK,   23'h7FFFFF},
          '{bsvr_pkg::STATUS_EMPTY,     23'h000000, 7'd0, 1'b1}}
    };

    bounded_stack_with_value_removal #(
        .CAPACITY (CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bsvr_pkg::rsp_t stack_apply(bsvr_pkg::cmd_t c);
        bsvr_pkg::rsp_t r;
        int             hit;
        r.status = bsvr_pkg::STATUS_OK;
        hit      = -1;
        case (c.mode)
            bsvr_pkg::MODE_PUSH:
            begin
                if (stack_depth >= CAP)
                begin
                    r.status = bsvr_pkg::STATUS_FULL;
                end
                else
                begin
                    stack_keys[stack_depth] = c.date_key;
                    stack_depth++;
                end
            end
            bsvr_pkg::MODE_POP:
            begin
                if (stack_depth == 0)
                    r.status = bsvr_pkg::STATUS_EMPTY;
                else
                    stack_depth--;
            end
            bsvr_pkg::MODE_PEEK:
            begin
                if (stack_depth == 0)
                    r.status = bsvr_pkg::STATUS_EMPTY;
            end
            default:
            begin
                for (int i = 0; i < stack_depth; i++)
                begin
                    if (hit < 0 && stack_keys[i] == c.date_key)
                        hit = i;
                end
                if (hit < 0)
                begin
                    r.status = bsvr_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    for (int i = hit; i < stack_depth - 1; i++)
                        stack_keys[i] = stack_keys[i + 1];
                    stack_depth--;
                end
            end
        endcase
        r.top_date = (stack_depth > 0) ? stack_keys[stack_depth - 1] : '0;
        r.depth    = bsvr_pkg::DEPTH_W'(stack_depth);
        r.is_empty = (stack_depth == 0);
        return r;
    endfunction

    function automatic logic [bsvr_pkg::KEY_W-1:0] pick_key();
        logic [bsvr_pkg::KEY_W-1:0] k;
        case ($urandom_range(3))
            0: k = bsvr_pkg::KEY_W'($urandom);
            1: k = {14'd2024, 4'd6, 5'($urandom_range(1, 4))};
            2: k = {14'($urandom_range(1970, 2099)), 4'($urandom_range(1, 12)),
                    5'($urandom_range(1, 31))};
            default: k = (stack_depth > 0) ? stack_keys[$urandom_range(stack_depth - 1)]
                                           : bsvr_pkg::KEY_W'($urandom);
        endcase
        return k;
    endfunction

    function automatic bsvr_pkg::cmd_t random_cmd(int regime);
        bsvr_pkg::cmd_t c;
        int             roll;
        int             w_push;
        int             w_pop;
        int             w_peek;
        roll = $urandom_range(99);
        case (regime)
            0:
            begin
                w_push = 70;
                w_pop  = 10;
                w_peek = 5;
            end
            1:
            begin
                w_push = 15;
                w_pop  = 45;
                w_peek = 10;
            end
            default:
            begin
                w_push = 25;
                w_pop  = 25;
                w_peek = 25;
            end
        endcase
        if (roll < w_push)
            c.mode = bsvr_pkg::MODE_PUSH;
        else if (roll < w_push + w_pop)
            c.mode = bsvr_pkg::MODE_POP;
        else if (roll < w_push + w_pop + w_peek)
            c.mode = bsvr_pkg::MODE_PEEK;
        else
            c.mode = bsvr_pkg::MODE_REMOVE;
        if (c.mode == bsvr_pkg::MODE_REMOVE && stack_depth > 0 && $urandom_range(3) != 0)
            c.date_key = stack_keys[$urandom_range(stack_depth - 1)];
        else
            c.date_key = pick_key();
        return c;
    endfunction

    task automatic issue(bsvr_pkg::cmd_t c, logic typed = 1'b0,
                         bsvr_pkg::rsp_t fixed_rsp = '0);
        bsvr_pkg::rsp_t predicted;
        predicted = stack_apply(c);
        rsp_expected.push_back(typed ? fixed_rsp : predicted);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic fill_and_drain();
        bsvr_pkg::cmd_t c;
        c.mode = bsvr_pkg::MODE_PUSH;
        while (stack_depth < CAP + 2)
        begin
            c.date_key = pick_key();
            issue(c);
            if (stack_depth == CAP)
            begin
                // push twice more into the full stack
                c.date_key = pick_key();
                issue(c);
                c.date_key = pick_key();
                issue(c);
                break;
            end
        end
        c.mode     = bsvr_pkg::MODE_REMOVE;
        c.date_key = stack_keys[0];
        issue(c);
        c.date_key = stack_keys[stack_depth / 2];
        issue(c);
        c.date_key = stack_keys[stack_depth - 1];
        issue(c);
        c.date_key = bsvr_pkg::KEY_W'($urandom);
        issue(c);
        c.mode = bsvr_pkg::MODE_POP;
        while (stack_depth > 0)
        begin
            c.date_key = bsvr_pkg::KEY_W'($urandom);
            issue(c);
        end
        issue(c);
        c.mode = bsvr_pkg::MODE_PEEK;
        issue(c);
    endtask

    always @(posedge clk)
    begin : rsp_check
        bsvr_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $display("%0t: unexpected transaction expected none actual %p",
                             $time, rsp);
                    errors++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.top_date !== want.top_date)
                    begin
                        $display("%0t: top_date expected %h actual %h",
                                 $time, want.top_date, rsp.top_date);
                        errors++;
                    end
                    if (rsp.depth !== want.depth)
                    begin
                        $display("%0t: depth expected %0d actual %0d",
                                 $time, want.depth, rsp.depth);
                        errors++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $display("%0t: is_empty expected %0b actual %0b",
                                 $time, want.is_empty, rsp.is_empty);
                        errors++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        bit timed_out;
        int regime;
        timed_out = 1'b0;
        regime    = 0;
        fork
            begin
                repeat (10)
                    @(posedge clk);
                rst_n <= 1'b1;
                @(posedge clk);
                for (int ph = 0; ph < 3; ph++)
                begin
                    snd_idle_pct  = SND_IDLE[ph];
                    rcv_stall_pct = RCV_STALL[ph];
                    if (ph == 0)
                    begin
                        for (int i = 0; i < DIR_N; i++)
                            issue(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
                    end
                    fill_and_drain();
                    for (int n = 0; n < RAND_PER_PHASE; n++)
                    begin
                        if (n % REGIME_LEN == 0)
                            regime = $urandom_range(2);
                        issue(random_cmd(regime));
                    end
                end
                cmd_valid <= 1'b0;
                while (rsp_expected.size() != 0)
                    @(posedge clk);
                repeat (TAIL_CYCLES)
                    @(posedge clk);
            end
            begin
                while (quiet_cycles < QUIET_LIMIT)
                    @(posedge clk);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
